[src/prr_pkg.sv]
// Shared constants and types for the polyphase rational resampler.
`timescale 1ns / 1ps

package prr_pkg;

    localparam int MAX_UP_FACTOR_DEF      = 16;
    localparam int MAX_TAPS_PER_PHASE_DEF = 32;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes, paddr[3:2]
    localparam logic [1:0] REG_UP_FACTOR      = 2'd0;
    localparam logic [1:0] REG_DOWN_FACTOR    = 2'd1;
    localparam logic [1:0] REG_TAPS_PER_PHASE = 2'd2;
    localparam logic [1:0] REG_SCALE          = 2'd3;

    localparam logic [4:0]  UP_FACTOR_RST      = 5'd1;
    localparam logic [4:0]  DOWN_FACTOR_RST    = 5'd1;
    localparam logic [5:0]  TAPS_PER_PHASE_RST = 6'd32;
    localparam logic [17:0] SCALE_RST          = 18'h10000;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_COEF   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE,
        ST_LOAD,
        ST_OUT
    } prr_state_t;

    typedef struct packed {
        logic sel_scale;
        logic acc_clr;
        logic acc_en;
    } prr_mac_ctl_t;

endpackage

[src/prr_mac.sv]
// Shared multiplier with product register and 32-bit wrapping accumulator.
`timescale 1ns / 1ps

module prr_mac (
    input  logic                 aclk,
    input  prr_pkg::prr_mac_ctl_t ctl,
    input  logic signed [15:0]   coef,
    input  logic signed [15:0]   hist,
    input  logic signed [17:0]   scale,
    output logic signed [33:0]   prod,
    output logic        [31:0]   acc
);
    import prr_pkg::*;

    logic signed [17:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [33:0] prod_reg;
    logic        [31:0] acc_reg;

    // scale pass: gain times accumulator bits [30:15]
    assign mul_a = ctl.sel_scale ? scale : {{2{coef[15]}}, coef};
    assign mul_b = ctl.sel_scale ? $signed(acc_reg[30:15]) : hist;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (ctl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctl.acc_en) begin
            acc_reg <= acc_reg + prod_reg[31:0];
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

[src/polyphase_rational_resampler_unit.sv]
// Top level of the polyphase rational resampler.
`timescale 1ns / 1ps
//
// Input channel s_*: one word is either a sample (s_action = 0) or a coefficient
// load (s_action = 1, h[s_coef_index] = s_coef_value). Coefficients must be
// loaded before samples that use them. Output channel m_*: resampled words,
// m_last marks the final word caused by one sample, m_overflow flags that the
// filter sum shifted by 15 did not fit in 16 bits.
// The APB port holds up_factor, down_factor, taps_per_phase and scale at byte
// addresses 0, 4, 8, 12; write only while the block is idle.
// A coefficient load is written as it is accepted. For a sample, the taps of
// each output word are walked one per cycle through the single shared
// multiplier, which also applies scale. One word is in work at a time; s_ready
// is low until the last output of a sample has been taken. A stalled receiver
// holds the output register and the block waits.
// Reset clears the history, write pointer, phase and registers; no clearing
// pass is needed. Coefficients are not reset.

module polyphase_rational_resampler_unit #(
    parameter int MAX_UP_FACTOR      = prr_pkg::MAX_UP_FACTOR_DEF,
    parameter int MAX_TAPS_PER_PHASE = prr_pkg::MAX_TAPS_PER_PHASE_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prr_pkg::PADDR_W-1:0]  paddr,
    input  logic [prr_pkg::PDATA_W-1:0]  pwdata,
    output logic [prr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_action,
    input  logic signed [15:0]           s_sample,
    input  logic [8:0]                   s_coef_index,
    input  logic signed [15:0]           s_coef_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [15:0]           m_out_sample,
    output logic                         m_last,
    output logic                         m_overflow
);
    import prr_pkg::*;

    localparam int COEF_DEPTH = MAX_UP_FACTOR * MAX_TAPS_PER_PHASE;
    localparam int UW  = $clog2(MAX_UP_FACTOR + 1);
    localparam int PW  = $clog2(2 * MAX_UP_FACTOR);
    localparam int TW  = $clog2(MAX_TAPS_PER_PHASE + 1);
    localparam int HAW = (MAX_TAPS_PER_PHASE > 1) ? $clog2(MAX_TAPS_PER_PHASE) : 1;
    localparam int CAW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

    // configuration
    logic [4:0]  up_reg;
    logic [4:0]  dn_reg;
    logic [5:0]  taps_reg;
    logic [17:0] scale_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg    <= UP_FACTOR_RST;
            dn_reg    <= DOWN_FACTOR_RST;
            taps_reg  <= TAPS_PER_PHASE_RST;
            scale_reg <= SCALE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_UP_FACTOR:      up_reg    <= pwdata[4:0];
                REG_DOWN_FACTOR:    dn_reg    <= pwdata[4:0];
                REG_TAPS_PER_PHASE: taps_reg  <= pwdata[5:0];
                REG_SCALE:          scale_reg <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_UP_FACTOR:      prdata = PDATA_W'(up_reg);
            REG_DOWN_FACTOR:    prdata = PDATA_W'(dn_reg);
            REG_TAPS_PER_PHASE: prdata = PDATA_W'(taps_reg);
            REG_SCALE:          prdata = PDATA_W'(scale_reg);
            default:            prdata = '0;
        endcase
    end

    // saturated settings
    logic [UW-1:0] up_c;
    logic [UW-1:0] dn_c;
    logic [TW-1:0] taps_c;

    assign up_c = (up_reg == '0) ? UW'(1) :
                  ((32'(up_reg) > MAX_UP_FACTOR) ? UW'(MAX_UP_FACTOR) : UW'(up_reg));
    assign dn_c = (dn_reg == '0) ? UW'(1) :
                  ((32'(dn_reg) > MAX_UP_FACTOR) ? UW'(MAX_UP_FACTOR) : UW'(dn_reg));
    assign taps_c = (taps_reg == '0) ? TW'(1) :
                    ((32'(taps_reg) > MAX_TAPS_PER_PHASE) ? TW'(MAX_TAPS_PER_PHASE)
                                                          : TW'(taps_reg));

    // control registers
    prr_state_t     state_reg, state_next;
    logic [HAW-1:0] wp_reg, wp_next;
    logic [PW-1:0]  phase_reg, phase_next;
    logic [PW-1:0]  d_reg, d_next;
    logic [HAW-1:0] w_reg, w_next;
    logic [TW-1:0]  tap_cnt_reg, tap_cnt_next;
    logic [HAW-1:0] hptr_reg, hptr_next;
    logic [CAW-1:0] caddr_reg, caddr_next;
    logic           rd_v_reg, rd_v_next;
    logic           mul_v_reg, mul_v_next;
    logic           m_valid_reg, m_valid_next;

    logic           s_acc;
    logic           sample_acc;
    logic           coef_acc;
    logic [HAW-1:0] w_cur;
    logic [PW-1:0]  d_sum;
    logic           out_load;
    prr_mac_ctl_t   mac_ctl;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_acc      = s_valid && s_ready;
    assign sample_acc = s_acc && (s_action == ACTION_SAMPLE);
    assign coef_acc   = s_acc && (s_action == ACTION_COEF);

    assign w_cur = (TW'(wp_reg) < taps_c) ? wp_reg : '0;
    assign d_sum = d_reg + PW'(dn_c);

    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        phase_next   = phase_reg;
        d_next       = d_reg;
        w_next       = w_reg;
        tap_cnt_next = tap_cnt_reg;
        hptr_next    = hptr_reg;
        caddr_next   = caddr_reg;
        rd_v_next    = 1'b0;
        mul_v_next   = rd_v_reg;
        m_valid_next = m_valid_reg;
        out_load     = 1'b0;
        mac_ctl      = '{sel_scale: 1'b0, acc_clr: 1'b0, acc_en: mul_v_reg};
        case (state_reg)
            ST_IDLE: begin
                if (sample_acc) begin
                    w_next     = w_cur;
                    wp_next    = ((TW'(w_cur) + TW'(1)) >= taps_c) ? '0 : w_cur + HAW'(1);
                    d_next     = phase_reg;
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE: begin
                if (d_reg < PW'(up_c)) begin
                    tap_cnt_next    = '0;
                    hptr_next       = w_reg;
                    caddr_next      = CAW'(d_reg);
                    mac_ctl.acc_clr = 1'b1;
                    state_next      = ST_MAC;
                end else begin
                    phase_next = d_reg - PW'(up_c);
                    state_next = ST_IDLE;
                end
            end
            ST_MAC: begin
                // one tap read per cycle, newest sample first
                rd_v_next    = 1'b1;
                tap_cnt_next = tap_cnt_reg + TW'(1);
                hptr_next    = (hptr_reg == '0) ? HAW'(taps_c - TW'(1))
                                                : hptr_reg - HAW'(1);
                caddr_next   = caddr_reg + CAW'(up_c);
                if ((tap_cnt_reg + TW'(1)) >= taps_c) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_v_reg && !mul_v_reg) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                mac_ctl.sel_scale = 1'b1;
                state_next        = ST_LOAD;
            end
            ST_LOAD: begin
                out_load     = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    d_next       = d_sum;
                    state_next   = ST_PHASE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            phase_reg   <= '0;
            rd_v_reg    <= 1'b0;
            mul_v_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            phase_reg   <= phase_next;
            rd_v_reg    <= rd_v_next;
            mul_v_reg   <= mul_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg       <= d_next;
        w_reg       <= w_next;
        tap_cnt_reg <= tap_cnt_next;
        hptr_reg    <= hptr_next;
        caddr_reg   <= caddr_next;
    end

    // coefficient store, no reset
    logic signed [15:0] coef_mem [COEF_DEPTH];
    logic signed [15:0] coef_rd_reg;

    always_ff @(posedge aclk) begin
        if (coef_acc && (32'(s_coef_index) < COEF_DEPTH)) begin
            coef_mem[CAW'(s_coef_index)] <= s_coef_value;
        end
        coef_rd_reg <= coef_mem[caddr_reg];
    end

    // sample history; entries not yet written read as zero
    logic signed [15:0]            hist_mem [MAX_TAPS_PER_PHASE];
    logic signed [15:0]            hist_rd_reg;
    logic [MAX_TAPS_PER_PHASE-1:0] hist_vld_reg;
    logic                          hist_vld_rd_reg;
    logic signed [15:0]            hist_op;

    always_ff @(posedge aclk) begin
        if (sample_acc) begin
            hist_mem[w_cur] <= s_sample;
        end
        hist_rd_reg <= hist_mem[hptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg    <= '0;
            hist_vld_rd_reg <= 1'b0;
        end else begin
            if (sample_acc) begin
                hist_vld_reg[w_cur] <= 1'b1;
            end
            hist_vld_rd_reg <= hist_vld_reg[hptr_reg];
        end
    end

    assign hist_op = hist_vld_rd_reg ? hist_rd_reg : '0;

    // shared multiplier and accumulator
    logic signed [33:0] prod;
    logic        [31:0] acc;

    prr_mac u_mac (
        .aclk  (aclk),
        .ctl   (mac_ctl),
        .coef  (coef_rd_reg),
        .hist  (hist_op),
        .scale ($signed(scale_reg)),
        .prod  (prod),
        .acc   (acc)
    );

    // output word register
    logic signed [15:0] out_sample_reg;
    logic               last_reg;
    logic               ovf_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_sample_reg <= prod[31:16];
            last_reg       <= (d_sum >= PW'(up_c));
            ovf_reg        <= acc[31] ^ acc[30];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = out_sample_reg;
    assign m_last       = last_reg;
    assign m_overflow   = ovf_reg;

endmodule

[src/prr_checker.sv]
// Port-level checks for the polyphase rational resampler, bound to the top level.
`timescale 1ns / 1ps

module prr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_action,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_out_sample,
    input logic        m_last
);
    import prr_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_sample) && $stable(m_last))
        else $error("output word changed while stalled");

    // no new word taken while an output is pending
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("input ready while output pending");

    a_coef_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == ACTION_COEF) |=> s_ready)
        else $error("coefficient load did not finish in one cycle");

    // more outputs follow a word without last
    a_more_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !s_ready)
        else $error("input ready before last output of a sample");

endmodule

bind polyphase_rational_resampler_unit prr_checker u_prr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_action     (s_action),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_sample (m_out_sample),
    .m_last       (m_last)
);

[tb/polyphase_rational_resampler_unit_tb.sv]
// Self-checking testbench for the polyphase rational resampler.
`timescale 1ns / 1ps

module polyphase_rational_resampler_unit_tb;
    import prr_pkg::*;

    localparam int MAX_UP        = MAX_UP_FACTOR_DEF;
    localparam int MAX_TAPS      = MAX_TAPS_PER_PHASE_DEF;
    localparam int COEF_DEPTH    = MAX_UP * MAX_TAPS;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 64;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic               last;
        logic               overflow;
    } resampled_word_t;

    class resample_scoreboard;
        logic [4:0]         up_reg;
        logic [4:0]         down_reg;
        logic [5:0]         taps_reg;
        logic [17:0]        scale_reg;
        logic signed [15:0] hist [MAX_TAPS];
        logic signed [15:0] coefs [COEF_DEPTH];
        bit                 loaded [COEF_DEPTH];
        int                 wr_ptr;
        int                 phase;
        resampled_word_t    predicted [$];
        int                 errors;

        function new();
            up_reg    = UP_FACTOR_RST;
            down_reg  = DOWN_FACTOR_RST;
            taps_reg  = TAPS_PER_PHASE_RST;
            scale_reg = SCALE_RST;
            foreach (hist[i]) hist[i] = '0;
            foreach (coefs[i]) begin
                coefs[i]  = '0;
                loaded[i] = 1'b0;
            end
            wr_ptr = 0;
            phase  = 0;
            errors = 0;
        endfunction

        function int clamp(int v, int hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int branches();
            return clamp(up_reg, MAX_UP);
        endfunction

        function int taps_eff();
            return clamp(taps_reg, MAX_TAPS);
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_UP_FACTOR:      up_reg    = v[4:0];
                REG_DOWN_FACTOR:    down_reg  = v[4:0];
                REG_TAPS_PER_PHASE: taps_reg  = v[5:0];
                REG_SCALE:          scale_reg = v[17:0];
                default: ;
            endcase
        endfunction

        // accepted input word: store a coefficient or run the filter branches it reaches
        function void absorb_word(logic action, logic signed [15:0] smp,
                                  logic [8:0] cidx, logic signed [15:0] cval);
            int                 up;
            int                 dn;
            int                 taps;
            int                 w;
            int                 d;
            int                 j;
            logic [31:0]        acc;
            logic signed [31:0] tap_prod;
            logic signed [15:0] t16;
            logic signed [63:0] gained;
            resampled_word_t    e;
            up   = clamp(up_reg, MAX_UP);
            dn   = clamp(down_reg, MAX_UP);
            taps = clamp(taps_reg, MAX_TAPS);
            if (action == ACTION_COEF) begin
                coefs[cidx]  = cval;
                loaded[cidx] = 1'b1;
                return;
            end
            // pointer left over from a longer history lands at entry 0
            w = (wr_ptr < taps) ? wr_ptr : 0;
            hist[w] = smp;
            wr_ptr = (w + 1 >= taps) ? 0 : w + 1;
            d = phase;
            while (d < up) begin
                acc = '0;
                for (j = 0; j < taps; j++) begin
                    tap_prod = coefs[j * up + d] * hist[(w + taps - j) % taps];
                    acc = acc + tap_prod;
                end
                t16 = acc[30:15];
                gained = t16 * $signed(scale_reg);
                e.out_sample = gained[31:16];
                e.last       = (d + dn >= up);
                e.overflow   = acc[31] ^ acc[30];
                predicted.push_back(e);
                d += dn;
            end
            phase = d - up;
        endfunction

        task report(string msg);
            errors++;
            // keep the log short on a badly broken block
            if (errors <= 100) $display("%0t: mismatch: %s", $realtime, msg);
        endtask

        task check_output(resampled_word_t got);
            resampled_word_t want;
            if (predicted.size() == 0) begin
                report($sformatf("unexpected word out_sample=%0d", got.out_sample));
                return;
            end
            want = predicted.pop_front();
            if (got.out_sample !== want.out_sample)
                report($sformatf("out_sample got %0d want %0d",
                                 got.out_sample, want.out_sample));
            if (got.last !== want.last)
                report($sformatf("last got %b want %b", got.last, want.last));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow got %b want %b", got.overflow, want.overflow));
        endtask
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [PADDR_W-1:0]          paddr;
    logic [PDATA_W-1:0]          pwdata;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_action;
    logic signed [15:0]          s_sample;
    logic [8:0]                  s_coef_index;
    logic signed [15:0]          s_coef_value;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [15:0]          m_out_sample;
    logic                        m_last;
    logic                        m_overflow;

    resample_scoreboard sb;
    bit                 rush;
    int                 cycles;

    polyphase_rational_resampler_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_sample     (s_sample),
        .s_coef_index (s_coef_index),
        .s_coef_value (s_coef_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample),
        .m_last       (m_last),
        .m_overflow   (m_overflow)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    initial cycles = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("polyphase_rational_resampler_unit_tb: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_output({m_out_sample, m_last, m_overflow});
    end

    // receiver: random stall before each word, none while rushing
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = rush ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_word(input logic action, input logic signed [15:0] smp,
                             input logic [8:0] cidx, input logic signed [15:0] cval);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= action;
        s_sample     <= smp;
        s_coef_index <= cidx;
        s_coef_value <= cval;
        do @(posedge aclk); while (!s_ready);
        sb.absorb_word(action, smp, cidx, cval);
    endtask

    task automatic drain_outputs();
        s_valid <= 1'b0;
        while (sb.predicted.size() != 0) @(posedge aclk);
        // a trailing coefficient load or silent sample may still be in work
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.write_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // upper bits of each write are noise; only the register width counts
    task automatic configure(input int up, input int dn, input int taps,
                             input logic [17:0] gain);
        drain_outputs();
        apb_write(REG_UP_FACTOR, ($urandom() & ~32'h1F) | 32'(up));
        apb_write(REG_DOWN_FACTOR, ($urandom() & ~32'h1F) | 32'(dn));
        apb_write(REG_TAPS_PER_PHASE, ($urandom() & ~32'h3F) | 32'(taps));
        apb_write(REG_SCALE, ($urandom() & ~32'h3FFFF) | 32'(gain));
    endtask

    // every coefficient the current setting can read gets loaded first
    task automatic fill_coefs();
        int i;
        for (i = 0; i < sb.branches() * sb.taps_eff(); i++)
            if (!sb.loaded[i]) push_word(ACTION_COEF, pick_value(), 9'(i), pick_value());
    endtask

    task automatic random_traffic(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 6) == 0)
                push_word(ACTION_COEF, pick_value(), 9'($urandom), pick_value());
            else
                push_word(ACTION_SAMPLE, pick_value(), 9'($urandom), pick_value());
        end
    endtask

    initial begin
        int n;
        sb = new();
        rush = 1'b0;
        aresetn      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        s_valid      <= 1'b0;
        s_action     <= ACTION_SAMPLE;
        s_sample     <= '0;
        s_coef_index <= '0;
        s_coef_value <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // two full-scale negative taps in branch 0 push the sum to 2^31
        configure(2, 1, 4, 18'h10000);
        push_word(ACTION_COEF, 16'sh0, 9'd0, 16'sh8000);
        push_word(ACTION_COEF, 16'sh0, 9'd2, 16'sh8000);
        push_word(ACTION_COEF, 16'sh0, 9'd1, 16'sh7FFF);
        push_word(ACTION_COEF, -16'sd1, 9'd511, 16'sh7FFF);
        fill_coefs();
        push_word(ACTION_SAMPLE, 16'sh8000, 9'd0, 16'sh0);
        push_word(ACTION_SAMPLE, 16'sh8000, 9'h1FF, -16'sd1);
        push_word(ACTION_SAMPLE, 16'sh7FFF, 9'd0, 16'sh0);
        push_word(ACTION_SAMPLE, 16'sh0, 9'd0, 16'sh0);
        push_word(ACTION_SAMPLE, -16'sd1, 9'd0, 16'sh0);
        push_word(ACTION_SAMPLE, 16'sd1, 9'd0, 16'sh0);

        // decimation: most samples give no word, phase runs past the branches
        configure(1, 16, 3, 18'h20000);
        fill_coefs();
        repeat (4) push_word(ACTION_SAMPLE, 16'sh8000, 9'd0, 16'sh0);
        // zero factors saturate to one
        configure(0, 0, 0, 18'h1FFFF);
        push_word(ACTION_SAMPLE, 16'sh7FFF, 9'd0, 16'sh0);
        push_word(ACTION_SAMPLE, 16'sh8000, 9'd0, 16'sh0);

        configure(16, 1, 2, 18'h3FFFF);
        fill_coefs();
        random_traffic(20);
        rush = 1'b1;
        configure(31, 5, 3, 18'($urandom));
        fill_coefs();
        random_traffic(25);
        rush = 1'b0;
        configure(1, 31, 40, 18'h10000);
        fill_coefs();
        random_traffic(40);
        configure(3, 2, 5, 18'h0);
        fill_coefs();
        random_traffic(25);
        configure(5, 7, 9, 18'($urandom));
        fill_coefs();
        random_traffic(25);
        for (n = 0; n < 3; n++) begin
            rush = (n == 2);
            configure($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 10),
                      18'($urandom));
            fill_coefs();
            random_traffic(25);
        end
        rush = 1'b0;

        drain_outputs();
        if (sb.errors == 0)
            $display("polyphase_rational_resampler_unit_tb: done, clean");
        else
            $display("polyphase_rational_resampler_unit_tb: done, errors");
        $finish;
    end

endmodule

[polyphase_rational_resampler_unit.f]
src/prr_pkg.sv
src/prr_mac.sv
src/polyphase_rational_resampler_unit.sv
src/prr_checker.sv
tb/polyphase_rational_resampler_unit_tb.sv
